// ===== rtl/bsenc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsenc_pkg
// Types, constants and the header byte lookup shared by the BMP stream encoder.
// ----------------------------------------------------------------------------
package bsenc_pkg;

	localparam int unsigned CFG_WIDTH = 13;

	// Register indexes of the configuration port.
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [31:0] HDR_BYTES      = 32'd54;
	localparam logic [31:0] INFO_BYTES     = 32'd40;
	localparam logic [31:0] PLANES         = 32'd1;
	localparam logic [31:0] BITS_PER_PIXEL = 32'd24;
	localparam logic [31:0] PELS_PER_METRE = 32'd2835;
	localparam logic [7:0]  CHAR_B         = 8'h42;
	localparam logic [7:0]  CHAR_M         = 8'h4D;

	// Byte positions in the sequence of one pixel: header, then blue, green, red.
	localparam logic [5:0] POS_HEADER = 6'd0;
	localparam logic [5:0] POS_PIXEL  = 6'd54;
	localparam logic [5:0] POS_RED    = 6'd56;

	// One classified pixel, handed from the front to the back.
	typedef struct packed {
		logic [23:0] pixel;
		logic        header;
		logic [1:0]  pad;
		logic        file_end;
	} entry_t;

	function automatic logic [7:0] le_byte(logic [31:0] v, logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0: b = v[7:0];
			2'd1: b = v[15:8];
			2'd2: b = v[23:16];
			default: b = v[31:24];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] hdr_byte(logic [5:0] idx, logic [31:0] fsize,
		logic [31:0] w, logic [31:0] h, logic [31:0] data);
		logic [5:0] off;
		logic [7:0] b;
		b = 8'h00;
		off = idx;
		case (idx) inside
			6'd0: b = CHAR_B;
			6'd1: b = CHAR_M;
			[6'd2:6'd5]: begin
				off = idx - 6'd2;
				b = le_byte(fsize, off[1:0]);
			end
			[6'd10:6'd13]: begin
				off = idx - 6'd10;
				b = le_byte(HDR_BYTES, off[1:0]);
			end
			[6'd14:6'd17]: begin
				off = idx - 6'd14;
				b = le_byte(INFO_BYTES, off[1:0]);
			end
			[6'd18:6'd21]: begin
				off = idx - 6'd18;
				b = le_byte(w, off[1:0]);
			end
			[6'd22:6'd25]: begin
				off = idx - 6'd22;
				b = le_byte(h, off[1:0]);
			end
			[6'd26:6'd27]: begin
				off = idx - 6'd26;
				b = le_byte(PLANES, off[1:0]);
			end
			[6'd28:6'd29]: begin
				off = idx - 6'd28;
				b = le_byte(BITS_PER_PIXEL, off[1:0]);
			end
			[6'd34:6'd37]: begin
				off = idx - 6'd34;
				b = le_byte(data, off[1:0]);
			end
			[6'd38:6'd45]: begin
				off = idx - 6'd38;
				b = le_byte(PELS_PER_METRE, off[1:0]);
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bsenc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsenc_front
// Configuration registers, pixel position counters and per-pixel classification.
// ----------------------------------------------------------------------------
module bsenc_front
	import bsenc_pkg::*;
#(
	parameter int unsigned MAX_DIM = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [CFG_WIDTH-1:0]         cfg_data,
	input  wire logic                         in_fire,
	input  wire logic [23:0]                  pixel_color,
	output logic      [$clog2(MAX_DIM+1)-1:0] dim_w,
	output logic      [$clog2(MAX_DIM+1)-1:0] dim_h,
	output entry_t                            entry
);

	localparam int unsigned DW = $clog2(MAX_DIM + 1);
	localparam int unsigned CW = $clog2(MAX_DIM);
	localparam int unsigned EW = (DW > CFG_WIDTH) ? DW : CFG_WIDTH;

	logic [CFG_WIDTH-1:0] width_q, height_q;
	logic [CW-1:0]        column_q, row_q;
	logic                 started_q;
	logic                 col_end, row_end;

	function automatic logic [DW-1:0] clamp_dim(logic [CFG_WIDTH-1:0] v);
		logic [EW-1:0] ext;
		logic [DW-1:0] r;
		ext = EW'(v);
		if (ext == '0) begin
			r = DW'(1);
		end else if (ext > EW'(MAX_DIM)) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(ext);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WIDTH'(1);
			height_q <= CFG_WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dim_w = clamp_dim(width_q);
	assign dim_h = clamp_dim(height_q);

	assign col_end = ((CW + 1)'(column_q) + (CW + 1)'(1)) >= (CW + 1)'(dim_w);
	assign row_end = ((CW + 1)'(row_q) + (CW + 1)'(1)) >= (CW + 1)'(dim_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			started_q <= 1'b0;
		end else if (in_fire) begin
			if (col_end) begin
				column_q <= '0;
				if (row_end) begin
					row_q     <= '0;
					started_q <= 1'b0;
				end else begin
					row_q     <= row_q + CW'(1);
					started_q <= 1'b1;
				end
			end else begin
				column_q  <= column_q + CW'(1);
				started_q <= 1'b1;
			end
		end
	end

	// Row padding up to a 4-byte stride equals the width modulo four.
	always_comb begin
		entry.pixel    = pixel_color;
		entry.header   = !started_q;
		entry.pad      = col_end ? dim_w[1:0] : 2'd0;
		entry.file_end = col_end && row_end;
	end

endmodule
`default_nettype wire

// ===== rtl/bsenc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsenc_queue
// Two-entry queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module bsenc_queue
	import bsenc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output logic        full,
	output logic        not_empty,
	output entry_t      head
);

	entry_t     slots_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bsenc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsenc_back
// Byte sequencer: header, color and padding bytes into the output register.
// ----------------------------------------------------------------------------
module bsenc_back
	import bsenc_pkg::*;
#(
	parameter int unsigned MAX_DIM = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] dim_w,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] dim_h,
	input  wire logic                         q_not_empty,
	input  wire entry_t                       q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [7:0]                   data_byte,
	output logic                              run_last,
	output logic                              file_last
);

	localparam int unsigned DW = $clog2(MAX_DIM + 1);
	localparam int unsigned SW = DW + 2;
	localparam int unsigned PW = SW + DW;

	logic [SW-1:0] stride_q;
	logic [31:0]   data_size_q;
	logic [PW-1:0] product;
	logic [31:0]   total_size;

	entry_t     entry_q;
	logic       busy_q;
	logic [5:0] pos_q;
	logic [5:0] last_pos;
	logic       out_can, advance, at_last;
	logic [7:0] next_byte;

	// Sizes follow the registers; they settle well before a header byte needs them.
	assign product = PW'(stride_q) * PW'(dim_h);
	always_ff @(posedge clk) begin
		stride_q    <= SW'(dim_w) + SW'(dim_w) + SW'(dim_w) + SW'(dim_w[1:0]);
		data_size_q <= 32'(product);
	end
	assign total_size = data_size_q + HDR_BYTES;

	assign last_pos = POS_RED + {4'd0, entry_q.pad};
	assign at_last  = (pos_q == last_pos);
	assign out_can  = !out_valid || !out_stall;
	assign advance  = busy_q && out_can;
	assign q_pop    = q_not_empty && (!busy_q || (advance && at_last));

	always_comb begin
		if (pos_q < POS_PIXEL) begin
			next_byte = hdr_byte(pos_q, total_size, 32'(dim_w), 32'(dim_h), data_size_q);
		end else if (pos_q == POS_PIXEL) begin
			next_byte = entry_q.pixel[7:0];
		end else if (pos_q == POS_PIXEL + 6'd1) begin
			next_byte = entry_q.pixel[15:8];
		end else if (pos_q == POS_RED) begin
			next_byte = entry_q.pixel[23:16];
		end else begin
			next_byte = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (advance && at_last) begin
				busy_q <= 1'b0;
			end
			if (out_can) begin
				out_valid <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			entry_q <= q_head;
			pos_q   <= q_head.header ? POS_HEADER : POS_PIXEL;
		end else if (advance) begin
			pos_q <= pos_q + 6'd1;
		end
		if (advance) begin
			data_byte <= next_byte;
			run_last  <= at_last;
			file_last <= at_last && entry_q.file_end;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmp24_stream_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_encoder
// Streams an uncompressed 24-bit BMP file: one pixel word in, its bytes out.
// ----------------------------------------------------------------------------
// A pixel passes the queue slot and the back's entry register before its first
// byte reaches the output register. That byte-wide register sets the rate: one
// byte per cycle unless the output stalls, three color bytes per pixel, plus 0 to 3
// padding bytes on a row's last pixel and 54 header bytes on a file's first.
// Reset clears the position counters, the queue and the output valid at once;
// both dimension registers reset to 1.
// ----------------------------------------------------------------------------
module bmp24_stream_encoder
	import bsenc_pkg::*;
#(
	parameter int unsigned MAX_DIM = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration: index 0 is image_width, index 1 is image_height.
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_data,
	// Pixel input channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [23:0]          pixel_color,
	// Byte output channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [7:0]           data_byte,
	output logic                      run_last,
	output logic                      file_last
);

	localparam int unsigned DW = $clog2(MAX_DIM + 1);

	logic [DW-1:0] dim_w, dim_h;
	entry_t        front_entry, q_head;
	logic          in_fire, q_full, q_not_empty, q_pop;

	// The front takes a word whenever the queue has room; it never waits on
	// the output side directly, so a pixel can be classified while the back
	// is still sending the bytes of earlier pixels.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	// The front owns the registers and the column and row counters. It decides
	// per pixel whether the header goes first, how much row padding follows,
	// and whether this pixel closes the file.
	bsenc_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_fire    (in_fire),
		.pixel_color(pixel_color),
		.dim_w      (dim_w),
		.dim_h      (dim_h),
		.entry      (front_entry)
	);

	// A two-entry queue decouples classification from byte sequencing.
	bsenc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_entry(front_entry),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// The back walks one byte position per cycle, unless the output stalls, through
	// header, color and padding bytes, and loads the next queued pixel on the cycle
	// that the current pixel's last byte is sent, so pixels follow without a gap.
	bsenc_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dim_w      (dim_w),
		.dim_h      (dim_h),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.run_last   (run_last),
		.file_last  (file_last)
	);

endmodule
`default_nettype wire

// ===== test/tb_bmp24_stream_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp24_stream_encoder
// Self-checking bench for the 24-bit BMP stream encoder. It feeds pixel words
// through the valid/stall input, predicts every header, color and padding byte
// of the file, and compares each output word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_encoder;
	import bsenc_pkg::*;

	// Slowest correct run: about 480 pixels, each up to 60 bytes, each byte possibly
	// held by a stall burst of the sink, plus sender gaps and one long hold. This
	// limit leaves a wide margin over such a run.
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int unsigned RANDOM_ITEMS  = 462;
	localparam int unsigned QUIET_ITEMS   = 60;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned DIM_LIMIT     = 4096;
	localparam int          DIRECTED_ROWS = 33;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic                 cfg_index   = CFG_IMAGE_WIDTH;
	logic [CFG_WIDTH-1:0] cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [23:0]          pixel_color = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [7:0]           data_byte;
	logic                 run_last;
	logic                 file_last;

	bmp24_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_color(pixel_color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.run_last   (run_last),
		.file_last  (file_last)
	);

	// One expected output word of the file.
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       file_last;
	} file_byte_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// A row of the directed table. For pixel rows, byte_count is the number of
	// bytes the pixel must produce when that number is obvious from the image
	// shape; zero means the count is taken from the encoder prediction instead.
	typedef struct {
		row_kind_t            kind;
		logic                 reg_sel;
		logic [CFG_WIDTH-1:0] value;
		logic [23:0]          color;
		int                   byte_count;
	} stim_row_t;

	// The directed walk: reset shape 1x1, a small 3x2 image with 3 bytes of row
	// padding, a 2-wide row with 2 bytes of padding, zero dimensions that must
	// act as 1, oversized dimensions that must act as the maximum, and shrinking
	// the image in the middle of a file so that the row and the file end at once.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 58},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 58},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd3,    24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd2,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h123456, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hABCDEF, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hFF0000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h0000FF, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h808080, 0},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd2,    24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd0,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h5A5AA5, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hA5A55A, 0},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd1,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hC3C33C, 58},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd8191, 24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd4097, 24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h010203, 57},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h040506, 3},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h070809, 3},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd1,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h0A0B0C, 4},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd1,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h0D0E0F, 4},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd4096, 24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd4096, 24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'hF0E1D2, 57},
		'{ROW_WRITE, CFG_IMAGE_WIDTH,  13'd1,    24'h000000, 0},
		'{ROW_WRITE, CFG_IMAGE_HEIGHT, 13'd1,    24'h000000, 0},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h2D3C4B, 4},
		'{ROW_PIXEL, CFG_IMAGE_WIDTH,  13'd0,    24'h7F80FF, 58}
	};

	// Encoder state as the bench sees it: the raw register values and the
	// position of the next pixel inside the current file.
	logic [CFG_WIDTH-1:0] width_reg  = 13'd1;
	logic [CFG_WIDTH-1:0] height_reg = 13'd1;
	logic [31:0]          col_pos    = '0;
	logic [31:0]          row_pos    = '0;
	bit                   header_sent = 1'b0;

	// Bytes still to come, oldest first, and the byte count of each pixel run.
	file_byte_t  pending_bytes [$];
	int          run_lengths [$];

	int unsigned bytes_predicted = 0;
	int unsigned bytes_checked   = 0;
	int unsigned run_count       = 0;
	int unsigned files_seen      = 0;
	int unsigned pixels_sent     = 0;
	int unsigned reg_writes      = 0;
	int unsigned mismatches      = 0;
	int unsigned cycle_count     = 0;

	// Shared between the sender and the sink: the chance in percent that a
	// burst of idle cycles starts, and a one-time request for a long hold.
	int unsigned idle_pct     = 0;
	bit          hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// A dimension register of 0 acts as 1, and anything above the maximum acts
	// as the maximum, in the header too.
	function automatic logic [31:0] dim_in_use(input logic [CFG_WIDTH-1:0] v);
		if (v == '0)
			return 32'd1;
		if (32'(v) > DIM_LIMIT)
			return DIM_LIMIT;
		return 32'(v);
	endfunction

	// Each row is padded to a multiple of four bytes.
	function automatic logic [31:0] padded_row_bytes(input logic [31:0] w);
		return ((w * 32'd3 + 32'd3) / 32'd4) * 32'd4;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		file_byte_t fb;
		fb = '{data: b, run_last: 1'b0, file_last: 1'b0};
		pending_bytes.insert(pending_bytes.size(), fb);
		bytes_predicted++;
	endtask

	task automatic push_le(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			push_byte(v[8*i +: 8]);
	endtask

	// Predict every byte that one accepted pixel word causes and advance the
	// position. The header comes first when a new file begins; the last pixel
	// of a row adds zero padding, and the last row closes the file.
	task automatic encode_pixel(input logic [23:0] color, output int produced);
		logic [31:0] w, h, data_size, pad;
		int unsigned start;
		bit          file_end;
		int          tail_idx;
		start = bytes_predicted;
		file_end = 1'b0;
		w = dim_in_use(width_reg);
		h = dim_in_use(height_reg);
		if (!header_sent) begin
			data_size = padded_row_bytes(w) * h;
			push_byte(CHAR_B);
			push_byte(CHAR_M);
			push_le(data_size + HDR_BYTES, 4);
			push_le(32'd0, 4);
			push_le(HDR_BYTES, 4);
			push_le(INFO_BYTES, 4);
			push_le(w, 4);
			push_le(h, 4);
			push_le(PLANES, 2);
			push_le(BITS_PER_PIXEL, 2);
			push_le(32'd0, 4);
			push_le(data_size, 4);
			push_le(PELS_PER_METRE, 4);
			push_le(PELS_PER_METRE, 4);
			push_le(32'd0, 4);
			push_le(32'd0, 4);
			header_sent = 1'b1;
		end
		push_byte(color[7:0]);
		push_byte(color[15:8]);
		push_byte(color[23:16]);
		if (col_pos + 32'd1 >= w) begin
			pad = padded_row_bytes(w) - w * 32'd3;
			for (int i = 0; i < int'(pad); i++)
				push_byte(8'h00);
			col_pos = '0;
			if (row_pos + 32'd1 >= h) begin
				row_pos = '0;
				header_sent = 1'b0;
				file_end = 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		tail_idx = pending_bytes.size() - 1;
		pending_bytes[tail_idx].run_last = 1'b1;
		pending_bytes[tail_idx].file_last = file_end;
		produced = int'(bytes_predicted - start);
	endtask

	// Registers are only written while the encoder is idle, so the callers
	// drain the output first. The enable is low again when the task returns.
	task automatic write_reg(input logic sel, input logic [CFG_WIDTH-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == CFG_IMAGE_WIDTH)
			width_reg = v;
		else
			height_reg = v;
		reg_writes++;
		@(posedge clk);
	endtask

	// Offer one pixel word and hold it until the encoder takes it. Valid stays
	// high into the next call unless a random gap follows.
	task automatic send_pixel(input logic [23:0] color, input int typed_count);
		int produced;
		in_valid <= 1'b1;
		pixel_color <= color;
		do
			@(posedge clk);
		while (in_stall);
		encode_pixel(color, produced);
		run_lengths.insert(run_lengths.size(), typed_count != 0 ? typed_count : produced);
		pixels_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted byte has been seen. The
	// queue is read at the falling edge so the check never races the monitor.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Mostly small shapes so files close often, now and then a zero, the exact
	// maximum, an oversized value or a mid-size one that leaves a file open.
	function automatic logic [CFG_WIDTH-1:0] pick_dim(input int unsigned small_max);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return CFG_WIDTH'(DIM_LIMIT);
			2: return CFG_WIDTH'($urandom_range(DIM_LIMIT + 1, 8191));
			3: return CFG_WIDTH'($urandom_range(10, 300));
			default: return CFG_WIDTH'($urandom_range(1, small_max));
		endcase
	endfunction

	// Output monitor: every accepted output word is matched against the oldest
	// predicted byte, and the length of each pixel run is checked when the
	// encoder flags its last byte.
	always @(posedge clk) begin : check_output
		file_byte_t want;
		int         want_len;
		if (arst_n && out_valid && !out_stall) begin
			bytes_checked++;
			run_count++;
			if (file_last)
				files_seen++;
			if (pending_bytes.size() == 0) begin
				log_mismatch($sformatf("byte %0d: unexpected word data=%02h run=%0b file=%0b",
					bytes_checked, data_byte, run_last, file_last));
			end else begin
				want = pending_bytes.pop_front();
				if (data_byte !== want.data || run_last !== want.run_last ||
					file_last !== want.file_last)
					log_mismatch($sformatf(
						"byte %0d: expected data=%02h run=%0b file=%0b, got data=%02h run=%0b file=%0b",
						bytes_checked, want.data, want.run_last, want.file_last,
						data_byte, run_last, file_last));
			end
			if (run_last === 1'b1) begin
				if (run_lengths.size() != 0) begin
					want_len = run_lengths.pop_front();
					if (want_len != int'(run_count))
						log_mismatch($sformatf("pixel run ending at byte %0d: expected %0d bytes, got %0d",
							bytes_checked, want_len, run_count));
				end
				run_count = 0;
			end
		end
	end

	// Output side: random stall bursts at the current rate, and once in the
	// run a long hold so that the encoder backs up and stalls its input.
	initial begin : byte_sink
		int unsigned span;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				for (span = 0; span < HOLD_CYCLES; span++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_sent;
		int unsigned seg_len;
		bit          hold_issued;
		random_sent = 0;
		hold_issued = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run without idling on either side.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				drain();
				write_reg(directed_rows[r].reg_sel, directed_rows[r].value);
			end else begin
				send_pixel(directed_rows[r].color, directed_rows[r].byte_count);
			end
		end

		// Random part: segments of random pixel words, most under a new shape.
		// Segments often end in the middle of a file, so the new shape also
		// exercises a row or file that has to end early.
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			seg_len = $urandom_range(4, 30);
			if (random_sent + QUIET_ITEMS >= RANDOM_ITEMS) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			if (!hold_issued && random_sent >= 150) begin
				hold_issued = 1'b1;
				hold_request = 1'b1;
				seg_len = 48;
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_IMAGE_WIDTH, pick_dim(9));
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_IMAGE_HEIGHT, pick_dim(4));
			for (int i = 0; i < int'(seg_len) && random_sent < RANDOM_ITEMS; i++) begin
				send_pixel(24'($urandom()), 0);
				random_sent++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Streamed %0d pixel words into %0d checked bytes, closing %0d files.",
			pixels_sent, bytes_checked, files_seen);
		$display("Applied %0d register writes, including zero, maximum and oversized shapes.",
			reg_writes);
		if (mismatches == 0 && pending_bytes.size() == 0 && run_lengths.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d bytes outstanding", mismatches, pending_bytes.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
